/* src/ncba_pkg.sv */
// ----------------------------------------------------------------------------
// ncba_pkg
// Shared constants and types of the node-to-cell box average block.
// ----------------------------------------------------------------------------
package ncba_pkg;

   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int NODES_XY_W   = 9;
   localparam int NODES_Z_W    = 16;
   localparam int FIFO_DEPTH   = 3;
   localparam int FIFO_PTR_W   = 2;
   localparam int FIFO_LEVEL_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NODES_X = 2'd0,
      CSR_NODES_Y = 2'd1,
      CSR_NODES_Z = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                    not_empty;
      logic [FIFO_LEVEL_W-1:0] level;
   } fifo_status_type;

endpackage

/* src/ncba_if.sv */
// ----------------------------------------------------------------------------
// ncba_if
// Stream interfaces for node beats in and cell beats out.
// ----------------------------------------------------------------------------
interface ncba_req_if #(parameter int SAMPLE_BITS = 16);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] node_value;

   modport source (output valid, output node_value, input ready);
   modport sink   (input valid, input node_value, output ready);
endinterface

interface ncba_rsp_if #(parameter int SAMPLE_BITS = 16);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS+2:0] cell_sum_eighths;
   logic                   last_cell;

   modport source (output valid, output cell_sum_eighths, output last_cell, input ready);
   modport sink   (input valid, input cell_sum_eighths, input last_cell, output ready);
endinterface

/* src/node_to_cell_box_average_3d.sv */
// ----------------------------------------------------------------------------
// node_to_cell_box_average_3d
// Streams grid nodes in raster order and emits the 2x2x2 corner sum of each
// cell that ends at the current node, plus a flag on the final cell.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  req_ch  | in        | valid/ready        | node_value
//  rsp_ch  | out       | valid/ready        | cell_sum_eighths, last_cell
//  csr_*   | in        | csr_we, no stall   | csr_index, csr_wdata
//
//  One node beat per cycle unless req_ch.ready is low; a cell beat passes
//  through the stage-1 registers and the result buffer. The limit is the
//  read-modify-write of the plane and pair-row RAMs, one read and one
//  write each per node. Reset clears position counters, pair registers and
//  the result buffer; RAM contents are not cleared.
//  req_ch.ready drops only when the three-entry result buffer is close to full.
// ----------------------------------------------------------------------------
module node_to_cell_box_average_3d #(
   parameter int MAX_NODES_X = 256,
   parameter int MAX_NODES_Y = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   ncba_req_if.sink                            req_ch,
   ncba_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [ncba_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ncba_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int X_W    = $clog2(MAX_NODES_X);
   localparam int Y_W    = $clog2(MAX_NODES_Y);
   localparam int ADDR_W = $clog2(MAX_NODES_X * MAX_NODES_Y);
   localparam int PAIR_W = SAMPLE_BITS + 1;
   localparam int SUM_W  = SAMPLE_BITS + 3;
   localparam int XC_W   = (X_W + 1 > ncba_pkg::NODES_XY_W) ? X_W + 1 : ncba_pkg::NODES_XY_W;
   localparam int YC_W   = (Y_W + 1 > ncba_pkg::NODES_XY_W) ? Y_W + 1 : ncba_pkg::NODES_XY_W;
   localparam int Z_W    = ncba_pkg::NODES_Z_W;

   localparam logic [XC_W-1:0] MAX_X_C = XC_W'(MAX_NODES_X);
   localparam logic [YC_W-1:0] MAX_Y_C = YC_W'(MAX_NODES_Y);

   // configuration
   logic [ncba_pkg::NODES_XY_W-1:0] nodes_x_ff, nodes_x_in;
   logic [ncba_pkg::NODES_XY_W-1:0] nodes_y_ff, nodes_y_in;
   logic [Z_W-1:0]                  nodes_z_ff, nodes_z_in;

   always_comb begin
      nodes_x_in = nodes_x_ff;
      nodes_y_in = nodes_y_ff;
      nodes_z_in = nodes_z_ff;
      if (csr_we) begin
         case (ncba_pkg::csr_index_type'(csr_index))
            ncba_pkg::CSR_NODES_X: nodes_x_in = csr_wdata[ncba_pkg::NODES_XY_W-1:0];
            ncba_pkg::CSR_NODES_Y: nodes_y_in = csr_wdata[ncba_pkg::NODES_XY_W-1:0];
            ncba_pkg::CSR_NODES_Z: nodes_z_in = csr_wdata[Z_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nodes_x_ff <= ncba_pkg::NODES_XY_W'(2);
         nodes_y_ff <= ncba_pkg::NODES_XY_W'(2);
         nodes_z_ff <= Z_W'(2);
      end else begin
         nodes_x_ff <= nodes_x_in;
         nodes_y_ff <= nodes_y_in;
         nodes_z_ff <= nodes_z_in;
      end
   end

   // last indices after clamping
   logic [XC_W-1:0] nx_ext, last_x_wide;
   logic [YC_W-1:0] ny_ext, last_y_wide;
   logic [X_W-1:0]  last_x;
   logic [Y_W-1:0]  last_y;
   logic [Z_W-1:0]  last_z;

   always_comb begin
      nx_ext = XC_W'(nodes_x_ff);
      ny_ext = YC_W'(nodes_y_ff);
      if (nx_ext < XC_W'(2)) begin
         last_x_wide = XC_W'(1);
      end else if (nx_ext > MAX_X_C) begin
         last_x_wide = MAX_X_C - 1'b1;
      end else begin
         last_x_wide = nx_ext - 1'b1;
      end
      if (ny_ext < YC_W'(2)) begin
         last_y_wide = YC_W'(1);
      end else if (ny_ext > MAX_Y_C) begin
         last_y_wide = MAX_Y_C - 1'b1;
      end else begin
         last_y_wide = ny_ext - 1'b1;
      end
      last_x = last_x_wide[X_W-1:0];
      last_y = last_y_wide[Y_W-1:0];
      last_z = (nodes_z_ff < Z_W'(2)) ? Z_W'(1) : nodes_z_ff - 1'b1;
   end

   // position and accept
   logic [X_W-1:0] pos_x_ff, pos_x_in;
   logic [Y_W-1:0] pos_y_ff, pos_y_in;
   logic [Z_W-1:0] pos_z_ff, pos_z_in;
   logic           end_x, end_y, end_z;
   logic           accept;

   ncba_pkg::fifo_status_type fifo_status;
   logic                      s1_valid_ff;
   logic [2:0]                pending;

   assign pending      = 3'(fifo_status.level) + 3'(s1_valid_ff);
   assign req_ch.ready = (pending <= 3'(ncba_pkg::FIFO_DEPTH - 1));
   assign accept       = req_ch.valid && req_ch.ready;

   assign end_x = (pos_x_ff >= last_x);
   assign end_y = (pos_y_ff >= last_y);
   assign end_z = (pos_z_ff >= last_z);

   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      if (accept) begin
         if (!end_x) begin
            pos_x_in = pos_x_ff + 1'b1;
         end else begin
            pos_x_in = '0;
            if (!end_y) begin
               pos_y_in = pos_y_ff + 1'b1;
            end else begin
               pos_y_in = '0;
               pos_z_in = end_z ? '0 : pos_z_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
      end else begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
      end
   end

   logic [ADDR_W-1:0] plane_addr;
   assign plane_addr = ADDR_W'(int'(pos_y_ff) * MAX_NODES_X + int'(pos_x_ff));

   // stage 1: store read data arrives
   logic [SAMPLE_BITS-1:0] s1_value_ff;
   logic [X_W-1:0]         s1_x_ff;
   logic [ADDR_W-1:0]      s1_addr_ff;
   logic                   s1_emit_ff;
   logic                   s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_value_ff <= req_ch.node_value;
         s1_x_ff     <= pos_x_ff;
         s1_addr_ff  <= plane_addr;
         s1_emit_ff  <= (pos_x_ff != '0) && (pos_y_ff != '0) && (pos_z_ff != '0);
         s1_last_ff  <= end_x && end_y && end_z;
      end
   end

   logic [SAMPLE_BITS-1:0] below;
   logic [PAIR_W-1:0]      above;
   logic [PAIR_W-1:0]      pair;
   logic [SUM_W-1:0]       sum;
   logic [PAIR_W-1:0]      prev_pair_this_row_ff;
   logic [PAIR_W-1:0]      prev_pair_row_above_ff;

   ncba_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_NODES_X * MAX_NODES_Y)
   ) u_plane_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_value_ff),
      .rd_en   (accept),
      .rd_addr (plane_addr),
      .rd_data (below)
   );

   ncba_ram #(
      .WIDTH (PAIR_W),
      .DEPTH (MAX_NODES_X)
   ) u_pair_row_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_x_ff),
      .wr_data (pair),
      .rd_en   (accept),
      .rd_addr (pos_x_ff),
      .rd_data (above)
   );

   assign pair = PAIR_W'(s1_value_ff) + PAIR_W'(below);
   assign sum  = SUM_W'(pair) + SUM_W'(prev_pair_this_row_ff)
               + SUM_W'(above) + SUM_W'(prev_pair_row_above_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pair_this_row_ff  <= '0;
         prev_pair_row_above_ff <= '0;
      end else if (s1_valid_ff) begin
         prev_pair_this_row_ff  <= pair;
         prev_pair_row_above_ff <= above;
      end
   end

   // result buffer
   logic [SUM_W:0] head_data;
   logic           pop;

   assign pop = rsp_ch.valid && rsp_ch.ready;

   ncba_out_fifo #(
      .WIDTH (SUM_W + 1)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff && s1_emit_ff),
      .push_data ({s1_last_ff, sum}),
      .pop       (pop),
      .head_data (head_data),
      .status    (fifo_status)
   );

   assign rsp_ch.valid            = fifo_status.not_empty;
   assign rsp_ch.cell_sum_eighths = head_data[SUM_W-1:0];
   assign rsp_ch.last_cell        = head_data[SUM_W];

endmodule

/* src/ncba_ram.sv */
// ----------------------------------------------------------------------------
// ncba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ncba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/ncba_out_fifo.sv */
// ----------------------------------------------------------------------------
// ncba_out_fifo
// Small result buffer between the datapath and the cell beat output.
// ----------------------------------------------------------------------------
module ncba_out_fifo #(
   parameter int WIDTH = 20
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          push_data,
   input  logic                      pop,
   output logic [WIDTH-1:0]          head_data,
   output ncba_pkg::fifo_status_type status
);

   localparam logic [ncba_pkg::FIFO_PTR_W-1:0] LAST_PTR =
      ncba_pkg::FIFO_PTR_W'(ncba_pkg::FIFO_DEPTH - 1);

   logic [WIDTH-1:0]                    entry_ff [ncba_pkg::FIFO_DEPTH];
   logic [ncba_pkg::FIFO_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [ncba_pkg::FIFO_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [ncba_pkg::FIFO_LEVEL_W-1:0]   level_ff, level_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data        = entry_ff[rd_ptr_ff];
   assign status.not_empty = (level_ff != '0);
   assign status.level     = level_ff;

endmodule
